// File: rtl/wsfe_pkg.sv
package wsfe_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned LEN_W = 63;
	localparam int unsigned STEP_W = 4;

	localparam logic [LEN_W-1:0] LEN7_MAX = LEN_W'(125);
	localparam logic [LEN_W-1:0] LEN16_MAX = LEN_W'(16'hFFFF);
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	typedef enum logic [1:0] {
		CMD_HDR,
		CMD_PAY,
		CMD_ERR
	} kind_t;

	typedef enum logic [1:0] {
		EXT_NONE,
		EXT_16,
		EXT_64
	} ext_t;

	// one queue entry: a whole header burst, a payload byte or an error
	typedef struct packed {
		kind_t            kind;
		ext_t             ext;
		logic [7:0]       hdr0;
		logic [7:0]       hdr1;
		logic [LEN_W-1:0] len;
		logic             msk;
		logic [31:0]      key;
		logic             pay_valid;
		logic [7:0]       pay_byte;
		logic             pay_end;
		logic [STEP_W-1:0] nlast;
	} cmd_t;

	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			2'd3: b = key[7:0];
			default: b = key[31:24];
		endcase
		return b;
	endfunction

	function automatic logic [STEP_W-1:0] ext_count(input ext_t ext);
		logic [STEP_W-1:0] n;
		case (ext)
			EXT_16: n = STEP_W'(2);
			EXT_64: n = STEP_W'(8);
			default: n = '0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/wsfe_in_if.sv
interface wsfe_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        frame_start;
	logic [62:0] frame_length;
	logic        fin_flag;
	logic [2:0]  reserved_bits;
	logic [3:0]  frame_opcode;
	logic        mask_enable;
	logic [31:0] mask_key;

	modport source (
		output valid, payload_byte, frame_start, frame_length, fin_flag,
		       reserved_bits, frame_opcode, mask_enable, mask_key,
		input  ready
	);
	modport sink (
		input  valid, payload_byte, frame_start, frame_length, fin_flag,
		       reserved_bits, frame_opcode, mask_enable, mask_key,
		output ready
	);
endinterface

// File: rtl/wsfe_out_if.sv
interface wsfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       error_flag;

	modport source (
		output valid, out_byte, run_last, frame_end, error_flag,
		input  ready
	);
	modport sink (
		input  valid, out_byte, run_last, frame_end, error_flag,
		output ready
	);
endinterface

// File: rtl/wsfe_front.sv
module wsfe_front import wsfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wsfe_in_if.sink    item,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic [LEN_W-1:0] left_q;
	logic [31:0]      key_q;
	logic             mask_q;
	logic [1:0]       idx_q;
	logic             open_q;

	logic             len_nz;
	logic [STEP_W-1:0] key_n;

	assign item.ready = !q_full;
	assign push = item.valid && !q_full;
	assign len_nz = item.frame_length != '0;
	assign key_n = item.mask_enable ? STEP_W'(4) : '0;

	always_comb begin
		cmd = '0;
		if (item.frame_start) begin
			cmd.kind = CMD_HDR;
			cmd.hdr0 = {item.fin_flag, item.reserved_bits, item.frame_opcode};
			if (item.frame_length <= LEN7_MAX) begin
				cmd.ext = EXT_NONE;
				cmd.hdr1 = {item.mask_enable, item.frame_length[6:0]};
			end else if (item.frame_length <= LEN16_MAX) begin
				cmd.ext = EXT_16;
				cmd.hdr1 = {item.mask_enable, LEN7_EXT16};
			end else begin
				cmd.ext = EXT_64;
				cmd.hdr1 = {item.mask_enable, LEN7_EXT64};
			end
			cmd.len = item.frame_length;
			cmd.msk = item.mask_enable;
			cmd.key = item.mask_key;
			cmd.pay_valid = len_nz;
			cmd.pay_byte = item.payload_byte ^
				(item.mask_enable ? item.mask_key[31:24] : 8'h00);
			cmd.pay_end = item.frame_length == LEN_W'(1);
			cmd.nlast = STEP_W'(1) + ext_count(cmd.ext) + key_n + STEP_W'(len_nz);
		end else if (open_q) begin
			cmd.kind = CMD_PAY;
			cmd.pay_valid = 1'b1;
			cmd.pay_byte = item.payload_byte ^ (mask_q ? key_byte(key_q, idx_q) : 8'h00);
			cmd.pay_end = left_q == LEN_W'(1);
		end else begin
			cmd.kind = CMD_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			key_q <= '0;
			mask_q <= 1'b0;
			idx_q <= '0;
			open_q <= 1'b0;
		end else if (push) begin
			if (item.frame_start) begin
				key_q <= item.mask_key;
				mask_q <= item.mask_enable;
				idx_q <= {1'b0, len_nz};
				left_q <= item.frame_length - LEN_W'(len_nz);
				open_q <= item.frame_length > LEN_W'(1);
			end else if (open_q) begin
				idx_q <= idx_q + 2'd1;
				left_q <= left_q - LEN_W'(1);
				open_q <= left_q != LEN_W'(1);
			end
		end
	end

endmodule

// File: rtl/wsfe_queue.sv
module wsfe_queue import wsfe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign empty = cnt_q == '0;
	assign full = cnt_q == QCNT_W'(QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/wsfe_back.sv
module wsfe_back import wsfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       q_empty,
	output logic       pop,
	wsfe_out_if.source result
);

	logic [STEP_W-1:0] step_q;
	logic              valid_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              end_q;
	logic              err_q;

	logic              adv;
	logic              last;
	logic [STEP_W-1:0] ext_n;
	logic [STEP_W-1:0] e;
	logic [STEP_W-1:0] k;
	logic [63:0]       word;
	logic [2:0]        sel;
	logic [7:0]        byte_d;
	logic              end_d;

	assign adv = !q_empty && (!valid_q || result.ready);
	assign last = step_q == head.nlast;
	assign pop = adv && last;

	assign ext_n = ext_count(head.ext);
	assign e = step_q - STEP_W'(2);
	assign k = e - ext_n;
	assign word = {1'b0, head.len};
	assign sel = 3'd7 - e[2:0];

	always_comb begin
		if (head.kind != CMD_HDR) begin
			byte_d = head.pay_byte;
		end else if (step_q == '0) begin
			byte_d = head.hdr0;
		end else if (step_q == STEP_W'(1)) begin
			byte_d = head.hdr1;
		end else if (e < ext_n) begin
			if (head.ext == EXT_16) begin
				byte_d = e[0] ? head.len[7:0] : head.len[15:8];
			end else begin
				byte_d = word[{sel, 3'b000} +: 8];
			end
		end else if (head.msk && k < STEP_W'(4)) begin
			byte_d = key_byte(head.key, k[1:0]);
		end else begin
			byte_d = head.pay_byte;
		end
	end

	always_comb begin
		case (head.kind)
			CMD_PAY: end_d = head.pay_end;
			CMD_HDR: end_d = head.pay_valid ? head.pay_end : 1'b1;
			default: end_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				step_q <= last ? '0 : step_q + STEP_W'(1);
				valid_q <= 1'b1;
			end else if (result.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_d;
			last_q <= last;
			end_q <= last && end_d;
			err_q <= head.kind == CMD_ERR;
		end
	end

	assign result.valid = valid_q;
	assign result.out_byte = byte_q;
	assign result.run_last = last_q;
	assign result.frame_end = end_q;
	assign result.error_flag = err_q;

endmodule

// File: rtl/websocket_frame_encoder_core.sv
// Items are registered in the command queue, result bytes in the output register.
// One result byte per cycle while the output is ready; a payload item gives one
// byte, a start item a burst of the output sequencer (header, length, key, byte).
// Input stalls only when the two-entry command queue is full, either behind a
// header burst or behind a stalled output.
// Reset (arst_n low, asynchronous): frame state, queue and output valid cleared.
module websocket_frame_encoder_core import wsfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	wsfe_in_if.sink    item,
	wsfe_out_if.source result
);

	logic push;
	logic pop;
	cmd_t cmd;
	cmd_t head;
	logic q_empty;
	logic q_full;

	wsfe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	wsfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	wsfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.result  (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full || pop)
		else $error("command queue overflow");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_empty)
		else $error("pushed command not visible");

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.error_flag |->
			result.out_byte == 8'h00 && result.run_last && !result.frame_end)
		else $error("malformed error result");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_end |-> result.run_last)
		else $error("frame end before last byte of transfer");

endmodule

// File: tb/sv/testbench.sv
module testbench;
	import wsfe_pkg::*;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned ITEM_TARGET = 480;

	typedef struct {
		logic [7:0]       pbyte;
		logic             start;
		logic [LEN_W-1:0] len;
		logic             fin;
		logic [2:0]       rsv;
		logic [3:0]       opc;
		logic             msk;
		logic [31:0]      key;
		bit               drain;
	} frame_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       error_flag;
	} enc_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	wsfe_in_if  in_ch();
	wsfe_out_if out_ch();

	websocket_frame_encoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	always #6 clk = ~clk;

	frame_item_t pending_items[$];
	enc_byte_t   frame_bytes_due[$];
	bit          drain_next = 1'b0;
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;

	// encoder state mirror
	logic [LEN_W-1:0] enc_left = '0;
	logic [31:0]      enc_key = '0;
	logic             enc_masking = 1'b0;
	logic [1:0]       enc_kidx = '0;
	logic             enc_open = 1'b0;

	function automatic enc_byte_t enc_byte(input logic [7:0] b, input logic fend,
			input logic err);
		enc_byte_t r;
		r.out_byte = b;
		r.run_last = 1'b0;
		r.frame_end = fend;
		r.error_flag = err;
		return r;
	endfunction

	function automatic enc_byte_t encode_payload_byte(input logic [7:0] pb);
		logic [7:0] b;
		b = pb;
		if (enc_masking)
			b = b ^ enc_key[8*(3-enc_kidx)+7 -: 8];
		enc_kidx = enc_kidx + 2'd1;
		enc_left = enc_left - LEN_W'(1);
		if (enc_left == '0)
			enc_open = 1'b0;
		return enc_byte(b, !enc_open, 1'b0);
	endfunction

	function automatic void predict_frame_bytes(input frame_item_t it);
		enc_byte_t  run[$];
		enc_byte_t  tail;
		logic [6:0] len7;
		logic [63:0] len64;
		if (it.start) begin
			enc_key = it.key;
			enc_masking = it.msk;
			enc_kidx = '0;
			enc_left = it.len;
			enc_open = (it.len != '0);
			if (it.len <= LEN7_MAX)
				len7 = it.len[6:0];
			else if (it.len <= LEN16_MAX)
				len7 = LEN7_EXT16;
			else
				len7 = LEN7_EXT64;
			len64 = {1'b0, it.len};
			run.push_back(enc_byte({it.fin, it.rsv, it.opc}, 1'b0, 1'b0));
			run.push_back(enc_byte({it.msk, len7}, 1'b0, 1'b0));
			if (len7 == LEN7_EXT16) begin
				for (int i = 1; i >= 0; i--)
					run.push_back(enc_byte(len64[8*i +: 8], 1'b0, 1'b0));
			end else if (len7 == LEN7_EXT64) begin
				for (int i = 7; i >= 0; i--)
					run.push_back(enc_byte(len64[8*i +: 8], 1'b0, 1'b0));
			end
			if (enc_masking) begin
				for (int i = 0; i < 4; i++)
					run.push_back(enc_byte(enc_key[31-8*i -: 8], 1'b0, 1'b0));
			end
			if (enc_open) begin
				run.push_back(encode_payload_byte(it.pbyte));
			end else begin
				// empty frame ends on its last header byte
				tail = run.pop_back();
				tail.frame_end = 1'b1;
				run.push_back(tail);
			end
		end else if (enc_open) begin
			run.push_back(encode_payload_byte(it.pbyte));
		end else begin
			run.push_back(enc_byte(8'h00, 1'b0, 1'b1));
		end
		tail = run.pop_back();
		tail.run_last = 1'b1;
		run.push_back(tail);
		foreach (run[i])
			frame_bytes_due.push_back(run[i]);
	endfunction

	function automatic void add_item(input logic start, input logic [LEN_W-1:0] len,
			input logic msk, input logic [7:0] hdr, input logic [31:0] key,
			input logic [7:0] pbyte);
		frame_item_t it;
		it.pbyte = pbyte;
		it.start = start;
		it.len = len;
		it.fin = hdr[7];
		it.rsv = hdr[6:4];
		it.opc = hdr[3:0];
		it.msk = msk;
		it.key = key;
		it.drain = drain_next;
		drain_next = 1'b0;
		pending_items.push_back(it);
	endfunction

	function automatic logic [LEN_W-1:0] rand_len63();
		return LEN_W'({$urandom, $urandom});
	endfunction

	function automatic void add_payload_bytes(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			add_item(1'b0, rand_len63(), 1'($urandom), 8'($urandom), $urandom,
				8'($urandom));
	endfunction

	// sender
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		frame_item_t nxt;
		logic        present;
		int unsigned burst_n;
		int unsigned gap_n;
		present = 1'b0;
		burst_n = burst_left;
		gap_n = gap_left;
		if (arst_n && !(in_ch.valid && !in_ch.ready)) begin
			if (gap_n != 0) begin
				gap_n--;
			end else if (pending_items.size() != 0 && !(pending_items[0].drain &&
					(frame_bytes_due.size() != 0 || in_ch.valid))) begin
				nxt = pending_items.pop_front();
				present = 1'b1;
				if (burst_n > 1) begin
					burst_n--;
				end else begin
					burst_n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
						: $urandom_range(1, 16);
					gap_n = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
				end
			end
			in_ch.valid <= present;
			if (present) begin
				in_ch.payload_byte <= nxt.pbyte;
				in_ch.frame_start <= nxt.start;
				in_ch.frame_length <= nxt.len;
				in_ch.fin_flag <= nxt.fin;
				in_ch.reserved_bits <= nxt.rsv;
				in_ch.frame_opcode <= nxt.opc;
				in_ch.mask_enable <= nxt.msk;
				in_ch.mask_key <= nxt.key;
			end
			burst_left <= burst_n;
			gap_left <= gap_n;
		end
	end

	// receiver
	int unsigned stall_left = 0;
	logic [1:0]  stall_mode = 2'd0;
	logic [7:0]  stall_tick = '0;

	always @(posedge clk) begin
		logic [7:0] pat;
		pat = 8'b1011_0110;
		stall_tick <= stall_tick + 8'd1;
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0: out_ch.ready <= 1'b1;
			2'd1: out_ch.ready <= pat[stall_tick[2:0]];
			2'd2: out_ch.ready <= ($urandom_range(0, 3) != 0);
			default: out_ch.ready <= stall_tick[3];
		endcase
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		frame_item_t seen;
		enc_byte_t   want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				seen.pbyte = in_ch.payload_byte;
				seen.start = in_ch.frame_start;
				seen.len = in_ch.frame_length;
				seen.fin = in_ch.fin_flag;
				seen.rsv = in_ch.reserved_bits;
				seen.opc = in_ch.frame_opcode;
				seen.msk = in_ch.mask_enable;
				seen.key = in_ch.mask_key;
				seen.drain = 1'b0;
				predict_frame_bytes(seen);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (frame_bytes_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result byte=%h last=%b end=%b err=%b",
							$realtime, out_ch.out_byte, out_ch.run_last,
							out_ch.frame_end, out_ch.error_flag);
					fail_count++;
				end else begin
					want = frame_bytes_due.pop_front();
					if (out_ch.out_byte !== want.out_byte ||
							out_ch.run_last !== want.run_last ||
							out_ch.frame_end !== want.frame_end ||
							out_ch.error_flag !== want.error_flag) begin
						if (fail_count < 10)
							$display("%0t: exp %h/%b/%b/%b got %h/%b/%b/%b",
								$realtime, want.out_byte, want.run_last,
								want.frame_end, want.error_flag, out_ch.out_byte,
								out_ch.run_last, out_ch.frame_end, out_ch.error_flag);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned      pick;
		int unsigned      n;
		logic [LEN_W-1:0] len;
		bit               must_start;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload_byte = '0;
		in_ch.frame_start = 1'b0;
		in_ch.frame_length = '0;
		in_ch.fin_flag = 1'b0;
		in_ch.reserved_bits = '0;
		in_ch.frame_opcode = '0;
		in_ch.mask_enable = 1'b0;
		in_ch.mask_key = '0;
		out_ch.ready = 1'b0;

		// directed: error with no frame, empty frames, length classes, abandon
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'hA5);
		add_item(1'b1, '0, 1'b0, 8'hFF, 32'hFFFF_FFFF, 8'h00);
		add_item(1'b1, '0, 1'b1, 8'h00, 32'hFFFF_FFFF, 8'hFF);
		add_item(1'b0, '1, 1'b1, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		add_item(1'b1, LEN_W'(1), 1'b1, 8'h81, 32'h0, 8'hFF);
		add_item(1'b1, LEN_W'(5), 1'b1, 8'h82, 32'h0123_4567, 8'h00);
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'hFF);
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'h5A);
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'hC3);
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'h3C);
		add_item(1'b1, LEN7_MAX, 1'b0, 8'h01, 32'h0, 8'h11);
		add_payload_bytes(1);
		add_item(1'b1, LEN_W'(126), 1'b1, 8'h02, 32'hA5A5_5A5A, 8'h22);
		add_payload_bytes(1);
		add_item(1'b1, LEN16_MAX, 1'b0, 8'h09, 32'h0, 8'h33);
		add_item(1'b1, LEN_W'(32'h1_0000), 1'b1, 8'h8A, 32'hDEAD_BEEF, 8'h44);
		add_payload_bytes(1);
		add_item(1'b1, '1, 1'b1, 8'hF8, 32'hFFFF_FFFF, 8'h55);
		add_payload_bytes(1);
		add_item(1'b1, LEN_W'(2), 1'b0, 8'h80, 32'h0, 8'h66);
		add_payload_bytes(1);
		add_item(1'b0, '0, 1'b0, 8'h00, 32'h0, 8'h77);

		// random: mostly complete frames, some abandoned, some stray bytes
		drain_next = 1'b1;
		must_start = 1'b0;
		while (pending_items.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 49) == 0)
				drain_next = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 8 && !must_start) begin
				add_payload_bytes($urandom_range(1, 2));
			end else begin
				must_start = 1'b0;
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					len = LEN_W'($urandom_range(0, 10));
				end else if (pick < 75) begin
					len = LEN_W'($urandom_range(11, 40));
				end else if (pick < 83) begin
					len = LEN_W'($urandom_range(120, 130));
				end else if (pick < 91) begin
					len = LEN_W'($urandom_range(131, 65535));
					must_start = 1'b1;
				end else begin
					len = rand_len63();
					if (len <= LEN16_MAX)
						len[40] = 1'b1;
					must_start = 1'b1;
				end
				if (must_start)
					n = $urandom_range(0, 8);
				else if (len > 1 && $urandom_range(0, 9) == 0) begin
					n = $urandom_range(0, int'(len) - 2);
					must_start = 1'b1;
				end else
					n = (len == 0) ? 0 : int'(len) - 1;
				add_item(1'b1, len, 1'($urandom), 8'($urandom), $urandom, 8'($urandom));
				add_payload_bytes(n);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_ch.valid)
			@(posedge clk);
		while (frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		fail_count += frame_bytes_due.size();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/wsfe_pkg.sv
rtl/wsfe_in_if.sv
rtl/wsfe_out_if.sv
rtl/wsfe_front.sv
rtl/wsfe_queue.sv
rtl/wsfe_back.sv
rtl/websocket_frame_encoder_core.sv
tb/sv/testbench.sv
